/* hdl/cpt_pkg.sv */
package cpt_pkg;

   // field widths
   localparam int VALUE_WIDTH = 17;
   localparam int COUNT_WIDTH = 3;

   // largest digit count for which rotations are tested
   localparam int MAX_DIGITS = 5;

   // bcd digits needed to hold any 17-bit value
   localparam int DIGIT_WIDTH = 4;
   localparam int NUM_BCD = 6;

   // trial divisor never passes sqrt(2^17) + 1
   localparam int DIV_WIDTH = 9;
   localparam int SQ_WIDTH = 2 * DIV_WIDTH;

   // counts one pass over the bits of a value
   localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH);

endpackage

/* hdl/cpt_req_if.sv */
interface cpt_req_if import cpt_pkg::*;;

   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);

endinterface

/* hdl/cpt_rsp_if.sv */
interface cpt_rsp_if import cpt_pkg::*;;

   logic                   valid;
   logic                   ready;
   logic                   is_prime;
   logic                   is_circular_prime;
   logic [COUNT_WIDTH-1:0] digit_count;

   modport source (output valid, output is_prime, output is_circular_prime,
                   output digit_count, input ready);
   modport sink (input valid, input is_prime, input is_circular_prime,
                 input digit_count, output ready);

endinterface

/* hdl/circular_prime_test_core.sv */
// flow: binary to bcd conversion, then for each tested number a trial division by each
//   divisor up to about sqrt(number), with a rotation and digit reassembly between tests
// throughput: one beat at a time, with the bit-serial remainder unit setting the rate
// reset: synchronous, active high; clears the sequencer and the result valid, ready is held
//   low during reset and the block takes a beat from the first cycle after reset falls
module circular_prime_test_core import cpt_pkg::*; (
   input logic   clock,
   input logic   reset,
   cpt_req_if.sink   req_if,
   cpt_rsp_if.source rsp_if
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_BCD  = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_TST  = 3'd4;
   localparam logic [2:0] S_ROT  = 3'd5;
   localparam logic [2:0] S_CONV = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   typedef logic [NUM_BCD-1:0][DIGIT_WIDTH-1:0] bcd_type;

   logic [2:0]               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   sr_ff, sr_in;
   logic [VALUE_WIDTH-1:0]   cand_ff, cand_in;
   logic [VALUE_WIDTH-1:0]   acc_ff, acc_in;
   bcd_type                  bcd_ff, bcd_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [COUNT_WIDTH-1:0]   n_ff, n_in;
   logic [COUNT_WIDTH-1:0]   rot_cnt_ff, rot_cnt_in;
   logic [COUNT_WIDTH-1:0]   conv_cnt_ff, conv_cnt_in;
   logic [DIV_WIDTH-1:0]     d_ff, d_in;
   logic [DIV_WIDTH-1:0]     rem_ff, rem_in;
   logic [SQ_WIDTH-1:0]      sq_ff, sq_in;
   logic                     first_ff, first_in;
   logic                     prime_ff, prime_in;
   logic                     circ_ff, circ_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_prime_ff, out_prime_in;
   logic                     out_circ_ff, out_circ_in;
   logic [COUNT_WIDTH-1:0]   out_count_ff, out_count_in;

   bcd_type                  dab_next;
   logic [COUNT_WIDTH-1:0]   dab_count;
   logic [DIV_WIDTH:0]       rem_shift;
   logic [COUNT_WIDTH-1:0]   conv_idx;
   logic [VALUE_WIDTH-1:0]   acc_next;
   logic                     test_end;
   logic                     test_pass;
   logic                     next_circ;
   logic                     more_rot;

   // one double-dabble step: correct digits, then shift in the next value bit
   always_comb begin
      bcd_type adj;
      adj = bcd_ff;
      for (int i = 0; i < NUM_BCD; i++) begin
         if (bcd_ff[i] >= DIGIT_WIDTH'(5)) begin
            adj[i] = bcd_ff[i] + DIGIT_WIDTH'(3);
         end
      end
      dab_next = {adj[NUM_BCD-1][DIGIT_WIDTH-2:0], adj[NUM_BCD-2:0], sr_ff[VALUE_WIDTH-1]};
      dab_count = COUNT_WIDTH'(1);
      for (int i = 0; i < NUM_BCD; i++) begin
         if (dab_next[i] != '0) begin
            dab_count = COUNT_WIDTH'(i + 1);
         end
      end
   end

   // restoring remainder step and rotation digit accumulate
   assign rem_shift = {rem_ff, sr_ff[VALUE_WIDTH-1]};
   assign conv_idx = n_ff - COUNT_WIDTH'(1) - conv_cnt_ff;
   assign acc_next = (acc_ff << 3) + (acc_ff << 1)
                   + VALUE_WIDTH'(bcd_ff[conv_idx]);

   // end of one primality test
   always_comb begin
      test_end = 1'b0;
      test_pass = 1'b0;
      if (state_ff == S_CHK) begin
         if (cand_ff < VALUE_WIDTH'(2)) begin
            test_end = 1'b1;
         end else if (sq_ff > SQ_WIDTH'(cand_ff)) begin
            test_end = 1'b1;
            test_pass = 1'b1;
         end
      end else if (state_ff == S_TST && rem_ff == '0) begin
         test_end = 1'b1;
      end
      next_circ = first_ff ? (test_pass && n_ff <= COUNT_WIDTH'(MAX_DIGITS))
                           : (circ_ff && test_pass);
      more_rot = ({1'b0, rot_cnt_ff} + 4'd1) < {1'b0, n_ff};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      sr_in = sr_ff;
      cand_in = cand_ff;
      acc_in = acc_ff;
      bcd_in = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      n_in = n_ff;
      rot_cnt_in = rot_cnt_ff;
      conv_cnt_in = conv_cnt_ff;
      d_in = d_ff;
      rem_in = rem_ff;
      sq_in = sq_ff;
      first_in = first_ff;
      prime_in = prime_ff;
      circ_in = circ_ff;
      out_prime_in = out_prime_ff;
      out_circ_in = out_circ_ff;
      out_count_in = out_count_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               sr_in = req_if.value;
               cand_in = req_if.value;
               bcd_in = '0;
               bit_cnt_in = '0;
               rot_cnt_in = '0;
               first_in = 1'b1;
               state_in = S_BCD;
            end
         end
         S_BCD: begin
            bcd_in = dab_next;
            sr_in = sr_ff << 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_WIDTH'(1);
            if (bit_cnt_ff == BIT_CNT_WIDTH'(VALUE_WIDTH - 1)) begin
               n_in = dab_count;
               d_in = DIV_WIDTH'(2);
               sq_in = SQ_WIDTH'(4);
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (!test_end) begin
               sr_in = cand_ff;
               rem_in = '0;
               bit_cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_shift >= {1'b0, d_ff}) begin
               rem_in = DIV_WIDTH'(rem_shift - {1'b0, d_ff});
            end else begin
               rem_in = rem_shift[DIV_WIDTH-1:0];
            end
            sr_in = sr_ff << 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_WIDTH'(1);
            if (bit_cnt_ff == BIT_CNT_WIDTH'(VALUE_WIDTH - 1)) begin
               state_in = S_TST;
            end
         end
         S_TST: begin
            if (!test_end) begin
               sq_in = sq_ff + SQ_WIDTH'({d_ff, 1'b1});
               d_in = d_ff + DIV_WIDTH'(1);
               state_in = S_CHK;
            end
         end
         S_ROT: begin
            // last digit moves to the front of the n-digit word
            for (int i = 0; i < NUM_BCD; i++) begin
               if (COUNT_WIDTH'(i) == n_ff - COUNT_WIDTH'(1)) begin
                  bcd_in[i] = bcd_ff[0];
               end else if (COUNT_WIDTH'(i) < n_ff - COUNT_WIDTH'(1)) begin
                  bcd_in[i] = bcd_ff[(i + 1) % NUM_BCD];
               end
            end
            rot_cnt_in = rot_cnt_ff + COUNT_WIDTH'(1);
            acc_in = '0;
            conv_cnt_in = '0;
            state_in = S_CONV;
         end
         S_CONV: begin
            acc_in = acc_next;
            conv_cnt_in = conv_cnt_ff + COUNT_WIDTH'(1);
            if (conv_cnt_ff == n_ff - COUNT_WIDTH'(1)) begin
               cand_in = acc_next;
               d_in = DIV_WIDTH'(2);
               sq_in = SQ_WIDTH'(4);
               state_in = S_CHK;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               out_prime_in = prime_ff;
               out_circ_in = circ_ff;
               out_count_in = n_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a finished test decides between the next rotation and the result
      if (test_end) begin
         if (first_ff) begin
            prime_in = test_pass;
         end
         first_in = 1'b0;
         circ_in = next_circ;
         state_in = (next_circ && more_rot) ? S_ROT : S_DONE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
      cand_ff <= cand_in;
      acc_ff <= acc_in;
      bcd_ff <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      n_ff <= n_in;
      rot_cnt_ff <= rot_cnt_in;
      conv_cnt_ff <= conv_cnt_in;
      d_ff <= d_in;
      rem_ff <= rem_in;
      sq_ff <= sq_in;
      first_ff <= first_in;
      prime_ff <= prime_in;
      circ_ff <= circ_in;
      out_prime_ff <= out_prime_in;
      out_circ_ff <= out_circ_in;
      out_count_ff <= out_count_in;
   end

   // ports
   assign req_if.ready = !reset && (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.is_prime = out_prime_ff;
   assign rsp_if.is_circular_prime = out_circ_ff;
   assign rsp_if.digit_count = out_count_ff;

   // checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff == S_BCD)
      else $error("accepted beat did not start conversion");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < d_ff)
      else $error("remainder not below divisor");

   a_circ_needs_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_circ_ff && !out_prime_ff))
      else $error("circular prime flagged on a non-prime");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> out_count_ff != '0 && out_count_ff <= COUNT_WIDTH'(NUM_BCD))
      else $error("digit count out of range");

endmodule

/* verif/tb.sv */
module tb;
   import cpt_pkg::*;

   // one answer as the block reports it
   typedef struct packed {
      logic                   is_prime;
      logic                   is_circular_prime;
      logic [COUNT_WIDTH-1:0] digit_count;
   } verdict_type;

   // an accepted candidate and the answer it must produce
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      verdict_type            verdict;
   } pending_type;

   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int TAIL_CYCLES = 40_000;
   localparam int REPORT_MAX  = 10;

   logic clock;
   logic reset;

   cpt_req_if req_bus ();
   cpt_rsp_if rsp_bus ();

   circular_prime_test_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   pending_type verdict_q [$];
   int          errors = 0;
   int          cycles = 0;
   int          rx_hold = 0;
   bit          tx_idle = 1'b1;
   bit          rx_idle = 1'b1;

   // known circular primes, used to steer random beats into the rotation checks
   int unsigned circ_pool [34] = '{
      2, 3, 5, 7, 11, 13, 17, 31, 37, 71, 73, 79, 97,
      113, 131, 197, 199, 311, 337, 373, 719, 733, 919, 971, 991,
      1193, 1931, 3119, 3779, 7793, 7937, 9311, 9377, 11939
   };

   // clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // plain trial division
   function automatic bit trial_prime(input int unsigned n);
      if (n < 2) return 1'b0;
      for (int unsigned d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // primality, rotation primality and digit count of one candidate
   function automatic verdict_type predict_verdict(input logic [VALUE_WIDTH-1:0] v);
      verdict_type res;
      int unsigned num;
      int unsigned rot;
      int unsigned scale;
      int unsigned ndig;
      bit          circ;
      num   = v;
      ndig  = 1;
      scale = 1;
      while (num >= 10) begin
         num = num / 10;
         ndig++;
         scale = scale * 10;
      end
      res.is_prime = trial_prime(v);
      circ = res.is_prime && (ndig <= MAX_DIGITS);
      // last digit moves to the front, leading zeros collapse numerically
      rot = v;
      for (int unsigned k = 1; circ && k < ndig; k++) begin
         rot = (rot % 10) * scale + rot / 10;
         if (!trial_prime(rot)) circ = 1'b0;
      end
      res.is_circular_prime = circ;
      res.digit_count = COUNT_WIDTH'(ndig);
      return res;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap(input bit en);
      int sel;
      if (!en) return 0;
      sel = $urandom_range(99);
      if (sel < 40) return 0;
      if (sel < 85) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // random candidate, weighted toward cheap values
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) return VALUE_WIDTH'($urandom_range(999));
      if (sel < 55) return VALUE_WIDTH'($urandom_range(9999));
      if (sel < 75) return VALUE_WIDTH'($urandom_range(99999));
      if (sel < 87) return VALUE_WIDTH'($urandom_range((1 << VALUE_WIDTH) - 1));
      return VALUE_WIDTH'(circ_pool[$urandom_range(33)]);
   endfunction

   // send one candidate; called and left at a falling edge, valid may stay high
   task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
      int          gap;
      pending_type item;
      gap = pick_gap(tx_idle);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= VALUE_WIDTH'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      item.value   = v;
      item.verdict = predict_verdict(v);
      verdict_q.push_back(item);
      @(negedge clock);
   endtask

   // drop valid and hold off until every answer is back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (verdict_q.size() != 0);
   endtask

   // response stalls
   always @(negedge clock) begin
      if (rx_hold == 0 && rx_idle && $urandom_range(3) == 0) rx_hold = pick_gap(1'b1);
      if (rx_hold != 0) begin
         rsp_bus.ready <= 1'b0;
         rx_hold--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // answer checker
   always @(posedge clock) begin
      pending_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (verdict_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected beat: p=%0b c=%0b n=%0d", rsp_bus.is_prime,
                        rsp_bus.is_circular_prime, rsp_bus.digit_count);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_bus.is_prime !== want.verdict.is_prime ||
                rsp_bus.is_circular_prime !== want.verdict.is_circular_prime ||
                rsp_bus.digit_count !== want.verdict.digit_count) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("mismatch value %0d: want p=%0b c=%0b n=%0d got p=%0b c=%0b n=%0d",
                           want.value, want.verdict.is_prime,
                           want.verdict.is_circular_prime, want.verdict.digit_count,
                           rsp_bus.is_prime, rsp_bus.is_circular_prime,
                           rsp_bus.digit_count);
            end
         end
      end
   end

   // zero, one, single digits and the first two-digit values
   task automatic test_edges();
      send_value(0);
      send_value(1);
      send_value(2);
      send_value(3);
      send_value(4);
      send_value(9);
      send_value(10);
      send_value(11);
   endtask

   // rotations, including ones that pick up leading zeros
   task automatic test_rotations();
      send_value(13);
      send_value(23);
      send_value(101);
      send_value(197);
      send_value(199);
      send_value(1193);
      send_value(11939);
      send_value(99371);
      send_value(99991);
   endtask

   // top of the nominal range, 2^16 and six digit values up to all ones
   task automatic test_wide_values();
      send_value(99999);
      send_value(100000);
      send_value(100003);
      send_value(65536);
      send_value(131070);
      send_value(131071);
   endtask

   // random candidates with idling on both sides
   task automatic test_random_mix(input int count);
      repeat (count) send_value(pick_value());
   endtask

   // random candidates with no idling at all
   task automatic test_back_to_back(input int count);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      repeat (count) send_value(pick_value());
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   // before every fifth candidate the sender holds off until the block has answered everything
   task automatic test_restart_after_drain(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 5 == 0) wait_drained();
         send_value(pick_value());
      end
   endtask

   // sequence
   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edges();
      test_rotations();
      test_wide_values();
      test_random_mix(40);
      test_back_to_back(20);
      test_restart_after_drain(20);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
